// File: rtl/concentric_disk_sample_unit_defines.svh
// ----------------------------------------------------------------------------
// Concentric disk sample unit: assertion macros
// Concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef CONCENTRIC_DISK_SAMPLE_UNIT_DEFINES_SVH
`define CONCENTRIC_DISK_SAMPLE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define CDSU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define CDSU_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define CDSU_ASSERT(lbl, prop, msg)
`define CDSU_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// File: rtl/cdsu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Concentric disk sample unit: package
// Widths, stage layout, constants and the arctangent table.
// ----------------------------------------------------------------------------
package cdsu_pkg;

  localparam int IN_W          = 16;
  localparam int OUT_W         = 16;
  localparam int OFF_W         = IN_W + 2;   // signed offset 2u - 2^16
  localparam int MAG_W         = IN_W + 1;   // |offset| up to 2^16
  localparam int REM_W         = MAG_W + 1;
  localparam int ANG_BITS      = 30;
  localparam int QUO_W         = ANG_BITS + 1;
  localparam int PROD_A_W      = QUO_W + ANG_BITS;
  localparam int CW            = 32;         // CORDIC x, y, z width
  localparam int CORDIC_STAGES = 16;
  localparam int OUT_FRAC_BITS = 15;
  localparam int OPROD_W       = OFF_W + CW;
  localparam int OSHIFT        = IN_W + ANG_BITS - OUT_FRAC_BITS;
  localparam int QW            = OPROD_W + 1 - OSHIFT;

  localparam logic [ANG_BITS-1:0] PI_QUARTER_Q30 = 30'd843314857;
  localparam logic signed [CW-1:0] GAIN_Q30      = 32'sd652032874;
  localparam logic signed [QW-1:0] OUT_LIM       = QW'((1 << OUT_FRAC_BITS) - 1);

  // stage layout
  localparam int ST_DIV0 = 1;
  localparam int ST_M1   = ST_DIV0 + QUO_W;
  localparam int ST_M2   = ST_M1 + 1;
  localparam int ST_COR0 = ST_M2 + 1;
  localparam int ST_P    = ST_COR0 + CORDIC_STAGES;
  localparam int ST_OUT  = ST_P + 1;
  localparam int NSTG    = ST_OUT + 1;

  typedef struct packed {
    logic signed [OFF_W-1:0] major;
    logic                    neg;
    logic                    swapped;
    logic                    zero;
  } side_t;

  function automatic logic signed [CW-1:0] atan_q30(input int i);
    case (i)
      0:       atan_q30 = 32'sd843314857;
      1:       atan_q30 = 32'sd497837829;
      2:       atan_q30 = 32'sd263043837;
      3:       atan_q30 = 32'sd133525159;
      4:       atan_q30 = 32'sd67021687;
      5:       atan_q30 = 32'sd33543516;
      6:       atan_q30 = 32'sd16775851;
      7:       atan_q30 = 32'sd8388437;
      8:       atan_q30 = 32'sd4194283;
      9:       atan_q30 = 32'sd2097149;
      10:      atan_q30 = 32'sd1048576;
      11:      atan_q30 = 32'sd524288;
      12:      atan_q30 = 32'sd262144;
      13:      atan_q30 = 32'sd131072;
      14:      atan_q30 = 32'sd65536;
      15:      atan_q30 = 32'sd32768;
      16:      atan_q30 = 32'sd16384;
      17:      atan_q30 = 32'sd8192;
      18:      atan_q30 = 32'sd4096;
      19:      atan_q30 = 32'sd2048;
      20:      atan_q30 = 32'sd1024;
      21:      atan_q30 = 32'sd512;
      22:      atan_q30 = 32'sd256;
      23:      atan_q30 = 32'sd128;
      default: atan_q30 = '0;
    endcase
  endfunction

endpackage

// File: rtl/cdsu_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Concentric disk sample unit: channel interfaces
// Valid/ready channels for square points in and disk points out.
// ----------------------------------------------------------------------------
interface cdsu_in_if;
  logic                     valid;
  logic                     ready;
  logic [cdsu_pkg::IN_W-1:0] u;
  logic [cdsu_pkg::IN_W-1:0] v;
  modport source (output valid, output u, output v, input ready);
  modport sink   (input valid, input u, input v, output ready);
endinterface

interface cdsu_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [cdsu_pkg::OUT_W-1:0] disk_x;
  logic signed [cdsu_pkg::OUT_W-1:0] disk_y;
  modport source (output valid, output disk_x, output disk_y, input ready);
  modport sink   (input valid, input disk_x, input disk_y, output ready);
endinterface

// File: rtl/concentric_disk_sample_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Concentric disk sample unit
// Maps a point of the unit square onto the unit disk (concentric mapping).
// ----------------------------------------------------------------------------
// Usage:
//   in_i  : sink channel, one beat = (u, v), unsigned Q0.16 coordinates.
//   out_o : source channel, one beat = (disk_x, disk_y), signed Q1.15,
//           rounded and saturated to +-32767.
//   Pipeline: 1 offset/select stage, 31 divider stages (one quotient bit
//   each), 2 angle-scaling stages, 16 CORDIC stages, 1 multiply stage and
//   1 round/saturate output register.
//   Throughput: one beat per cycle while out_o is not stalled, set by the
//   fully pipelined divider and CORDIC; every stage holds its own item.
//   Stall: all stages share one advance enable. While out_o holds a beat
//   that is not taken, the pipe freezes and in_i.ready drops; nothing is
//   lost or repeated. Bubbles ahead of the output do not close up during
//   a stall.
//   Reset: rst_ni clears all stage valid bits; no beat is in flight after.
// ----------------------------------------------------------------------------
`include "concentric_disk_sample_unit_defines.svh"

module concentric_disk_sample_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  cdsu_in_if.sink    in_i,
  cdsu_out_if.source out_o
);
  import cdsu_pkg::*;

  logic              adv;
  logic [NSTG-1:0]   vld_q;
  side_t             side_q [NSTG];

  // stage 0: offsets and major/minor selection
  logic [MAG_W-1:0]  amaj_q, amin_q;
  side_t             s0_d;
  logic [MAG_W-1:0]  amaj_d, amin_d;
  logic signed [OFF_W-1:0] ox, oy;
  logic [MAG_W-1:0]  ax, ay;

  // divider
  logic [REM_W-1:0]  rem_q  [QUO_W];
  logic [QUO_W-1:0]  quo_q  [QUO_W];
  logic [MAG_W-1:0]  dden_q [QUO_W];
  logic [REM_W-1:0]  rem_d  [QUO_W];
  logic [QUO_W-1:0]  quo_d  [QUO_W];

  // angle scaling
  logic [PROD_A_W-1:0] aprod_q;
  logic [PROD_A_W-1:0] aprod_r;
  logic signed [CW-1:0] z0_d, z0_q;

  // CORDIC
  logic signed [CW-1:0] cx_q [CORDIC_STAGES];
  logic signed [CW-1:0] cy_q [CORDIC_STAGES];
  logic signed [CW-1:0] cz_q [CORDIC_STAGES];
  logic signed [CW-1:0] cx_d [CORDIC_STAGES];
  logic signed [CW-1:0] cy_d [CORDIC_STAGES];
  logic signed [CW-1:0] cz_d [CORDIC_STAGES];

  // output multiply and rounding
  logic signed [OPROD_W-1:0] px_q, py_q;
  logic signed [OUT_W-1:0]   dx_d, dy_d, dx_q, dy_q;

  function automatic logic signed [OUT_W-1:0] round_sat(
    input logic signed [OPROD_W-1:0] p
  );
    logic signed [OPROD_W:0] s;
    logic signed [QW-1:0]    q;
    s = {p[OPROD_W-1], p} + ((OPROD_W + 1)'(1) << (OSHIFT - 1));
    q = QW'(s >>> OSHIFT);
    if (q > OUT_LIM)       q = OUT_LIM;
    else if (q < -OUT_LIM) q = -OUT_LIM;
    round_sat = q[OUT_W-1:0];
  endfunction

  assign adv        = out_o.ready || !out_o.valid;
  assign in_i.ready = adv;

  // ---- stage 0 logic ----
  always_comb begin
    ox = $signed({1'b0, in_i.u, 1'b0}) - $signed(OFF_W'(1) << IN_W);
    oy = $signed({1'b0, in_i.v, 1'b0}) - $signed(OFF_W'(1) << IN_W);
    ax = ox[OFF_W-1] ? MAG_W'(-ox) : MAG_W'(ox);
    ay = oy[OFF_W-1] ? MAG_W'(-oy) : MAG_W'(oy);
    s0_d.zero = (ox == '0) && (oy == '0);
    // ties go to the second axis
    if (ax > ay) begin
      s0_d.major   = ox;
      s0_d.swapped = 1'b0;
      amaj_d       = ax;
      amin_d       = ay;
    end else begin
      s0_d.major   = oy;
      s0_d.swapped = 1'b1;
      amaj_d       = ay;
      amin_d       = ax;
    end
    s0_d.neg = ox[OFF_W-1] ^ oy[OFF_W-1];
  end

  // ---- restoring divider, one quotient bit per stage, MSB first ----
  always_comb begin
    logic [REM_W-1:0] base;
    logic [MAG_W-1:0] den;
    logic             ge;
    for (int k = 0; k < QUO_W; k++) begin
      if (k == 0) begin
        base     = {1'b0, amin_q};
        den      = amaj_q;
        quo_d[k] = '0;
      end else begin
        base     = {rem_q[k-1][REM_W-2:0], 1'b0};
        den      = dden_q[k-1];
        quo_d[k] = quo_q[k-1];
      end
      ge       = base >= {1'b0, den};
      rem_d[k] = ge ? base - {1'b0, den} : base;
      quo_d[k][QUO_W-1-k] = ge;
    end
  end

  // ---- angle: round(ratio * pi/4) with sign ----
  always_comb begin
    logic [PROD_A_W:0] s;
    s    = {1'b0, aprod_q} + ((PROD_A_W + 1)'(1) << (ANG_BITS - 1));
    z0_d = CW'(s >> ANG_BITS);
    if (side_q[ST_M2-1].neg) z0_d = -z0_d;
    aprod_r = PROD_A_W'(quo_q[QUO_W-1]) * PROD_A_W'(PI_QUARTER_Q30);
  end

  // ---- CORDIC rotation ----
  always_comb begin
    logic signed [CW-1:0] x, y, z;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      if (i == 0) begin
        x = GAIN_Q30;
        y = '0;
        z = z0_q;
      end else begin
        x = cx_q[i-1];
        y = cy_q[i-1];
        z = cz_q[i-1];
      end
      if (!z[CW-1]) begin
        cx_d[i] = x - (y >>> i);
        cy_d[i] = y + (x >>> i);
        cz_d[i] = z - atan_q30(i);
      end else begin
        cx_d[i] = x + (y >>> i);
        cy_d[i] = y - (x >>> i);
        cz_d[i] = z + atan_q30(i);
      end
    end
  end

  always_comb begin
    if (side_q[ST_P].zero) begin
      dx_d = '0;
      dy_d = '0;
    end else begin
      dx_d = round_sat(px_q);
      dy_d = round_sat(py_q);
    end
  end

  // ---- valid bits ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NSTG-2:0], in_i.valid};
    end
  end

  // ---- payload ----
  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= s0_d;
      for (int s = 1; s < NSTG; s++) side_q[s] <= side_q[s-1];
      amaj_q <= amaj_d;
      amin_q <= amin_d;
      for (int k = 0; k < QUO_W; k++) begin
        rem_q[k]  <= rem_d[k];
        quo_q[k]  <= quo_d[k];
        dden_q[k] <= (k == 0) ? amaj_q : dden_q[(k == 0) ? 0 : k-1];
      end
      aprod_q <= aprod_r;
      z0_q    <= z0_d;
      for (int i = 0; i < CORDIC_STAGES; i++) begin
        cx_q[i] <= cx_d[i];
        cy_q[i] <= cy_d[i];
        cz_q[i] <= cz_d[i];
      end
      if (!side_q[ST_P-1].swapped) begin
        px_q <= OPROD_W'(side_q[ST_P-1].major) * OPROD_W'(cx_q[CORDIC_STAGES-1]);
        py_q <= OPROD_W'(side_q[ST_P-1].major) * OPROD_W'(cy_q[CORDIC_STAGES-1]);
      end else begin
        px_q <= OPROD_W'(side_q[ST_P-1].major) * OPROD_W'(cy_q[CORDIC_STAGES-1]);
        py_q <= OPROD_W'(side_q[ST_P-1].major) * OPROD_W'(cx_q[CORDIC_STAGES-1]);
      end
      dx_q <= dx_d;
      dy_q <= dy_d;
    end
  end

  assign out_o.valid  = vld_q[ST_OUT];
  assign out_o.disk_x = dx_q;
  assign out_o.disk_y = dy_q;

  // ---- assertions ----
  `CDSU_ASSERT(a_x_sat, out_o.valid |-> (out_o.disk_x != 16'sh8000), "disk_x not saturated")
  `CDSU_ASSERT(a_y_sat, out_o.valid |-> (out_o.disk_y != 16'sh8000), "disk_y not saturated")
  `CDSU_ASSERT_RST(a_rdy, in_i.ready == (out_o.ready || !out_o.valid), "ready mismatch")
  `CDSU_ASSERT(a_hold, (out_o.valid && !out_o.ready) |=> $stable(vld_q), "pipe moved on stall")

endmodule
